>>> rtl/core/q2e_pkg.sv
package q2e_pkg;

    localparam int COMP_W       = 16;
    localparam int ANGLE_W      = 16;
    localparam int PROD_W       = 2 * COMP_W;
    localparam int ARG_W        = 34;
    localparam int Z_W          = 34;
    localparam int ROOT_W       = 31;
    localparam int RAD_W        = 61;
    localparam int SQRT_W       = RAD_W + 1;
    localparam int SQRT_STEPS   = 31;
    localparam int CORDIC_STEPS = 32;
    localparam int ATAN_LAT     = CORDIC_STEPS + 4;
    localparam int TOL_W        = 16;

    localparam logic signed [ARG_W-1:0] ONE_Q30      = 34'sh0_4000_0000;
    localparam logic signed [Z_W-1:0]   TURN_QUARTER = 34'sh0_4000_0000;
    localparam logic signed [Z_W-1:0]   TURN_HALF    = 34'sh0_8000_0000;
    localparam logic [RAD_W-1:0]        RAD_ONE      = 61'h1000_0000_0000_0000;
    localparam logic [TOL_W-1:0]        TOL_RESET    = 16'd1074;

    typedef enum logic [1:0] {
        KIND_REGULAR = 2'd0,
        KIND_NORTH   = 2'd1,
        KIND_SOUTH   = 2'd2
    } pole_kind_t;

    // operands handed from the front end through the root pipeline
    typedef struct packed {
        pole_kind_t              kind;
        logic signed [ARG_W-1:0] ay;
        logic signed [ARG_W-1:0] ax;
        logic signed [ARG_W-1:0] by;
        logic signed [ARG_W-1:0] bx;
        logic signed [31:0]      t30;
    } side_t;

    // arctan(2^-i) in units of 2^-32 turn
    function automatic logic signed [Z_W-1:0] cordic_angle(input int i);
        logic signed [Z_W-1:0] a;
        unique case (i)
            0:  a = 34'sd536870912;
            1:  a = 34'sd316933406;
            2:  a = 34'sd167458907;
            3:  a = 34'sd85004756;
            4:  a = 34'sd42667331;
            5:  a = 34'sd21353441;
            6:  a = 34'sd10679838;
            7:  a = 34'sd5340245;
            8:  a = 34'sd2670163;
            9:  a = 34'sd1335087;
            10: a = 34'sd667544;
            11: a = 34'sd333772;
            12: a = 34'sd166886;
            13: a = 34'sd83443;
            14: a = 34'sd41722;
            15: a = 34'sd20861;
            16: a = 34'sd10430;
            17: a = 34'sd5215;
            18: a = 34'sd2608;
            19: a = 34'sd1304;
            20: a = 34'sd652;
            21: a = 34'sd326;
            22: a = 34'sd163;
            23: a = 34'sd81;
            24: a = 34'sd41;
            25: a = 34'sd20;
            26: a = 34'sd10;
            27: a = 34'sd5;
            28: a = 34'sd3;
            29: a = 34'sd1;
            30: a = 34'sd1;
            default: a = 34'sd0;
        endcase
        return a;
    endfunction

endpackage

>>> rtl/core/q2e_front.sv
module q2e_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  logic                               in_valid,
    input  logic signed [q2e_pkg::COMP_W-1:0]  qx,
    input  logic signed [q2e_pkg::COMP_W-1:0]  qy,
    input  logic signed [q2e_pkg::COMP_W-1:0]  qz,
    input  logic signed [q2e_pkg::COMP_W-1:0]  qw,
    input  logic [q2e_pkg::TOL_W-1:0]          tol,
    output logic                               out_valid,
    output logic [q2e_pkg::RAD_W-1:0]          out_rad,
    output q2e_pkg::side_t                     out_side
);
    import q2e_pkg::*;

    logic [3:0] vld_reg;

    // stage 1: products
    logic signed [PROD_W-1:0] xx_reg, yy_reg, zz_reg, ww_reg, xy_reg, zw_reg;
    logic signed [PROD_W-1:0] yz_reg, xw_reg, yw_reg, xz_reg;
    logic signed [COMP_W-1:0] x1_reg, w1_reg;

    // stage 2: sums
    logic signed [ARG_W-1:0] test_reg, hy_reg, hx_reg, by_reg, bx_reg;
    logic signed [ARG_W-1:0] test_next, hy_next, hx_next, by_next, bx_next;
    logic signed [COMP_W-1:0] x2_reg, w2_reg;

    // stage 3: pole test, operand choice, clamp
    side_t                side3_reg, side3_next;
    logic [ROOT_W-1:0]    mag3_reg, mag3_next;

    // stage 4: radicand
    side_t                side4_reg;
    logic [RAD_W-1:0]     rad4_reg, rad4_next;

    logic signed [ARG_W:0]   dn, ds, tl;
    logic signed [ARG_W-1:0] tc;
    logic [2*ROOT_W-1:0]     sq;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[2:0], in_valid};
        end
    end

    always_comb
    begin
        test_next = (ARG_W'(yw_reg) - ARG_W'(xz_reg)) <<< 1;
        hy_next   = (ARG_W'(xy_reg) + ARG_W'(zw_reg)) <<< 1;
        by_next   = (ARG_W'(yz_reg) + ARG_W'(xw_reg)) <<< 1;
        hx_next   = ARG_W'(xx_reg) - ARG_W'(yy_reg) - ARG_W'(zz_reg) + ARG_W'(ww_reg);
        bx_next   = ARG_W'(zz_reg) + ARG_W'(ww_reg) - ARG_W'(xx_reg) - ARG_W'(yy_reg);
    end

    always_comb
    begin
        tl = $signed({{(ARG_W + 1 - TOL_W){1'b0}}, tol});
        dn = (ARG_W + 1)'(test_reg) - (ARG_W + 1)'(ONE_Q30);
        ds = (ARG_W + 1)'(test_reg) + (ARG_W + 1)'(ONE_Q30);
        if (test_reg > ONE_Q30)
            tc = ONE_Q30;
        else if (test_reg < -ONE_Q30)
            tc = -ONE_Q30;
        else
            tc = test_reg;
        mag3_next = (tc < 0) ? ROOT_W'(-tc) : ROOT_W'(tc);

        side3_next.by  = by_reg;
        side3_next.bx  = bx_reg;
        side3_next.t30 = 32'(tc);
        // north checked first; at a pole the heading path takes atan2(x, w)
        priority if (dn >= -tl && dn <= tl)
        begin
            side3_next.kind = KIND_NORTH;
            side3_next.ay   = ARG_W'(x2_reg);
            side3_next.ax   = ARG_W'(w2_reg);
        end
        else if (ds >= -tl && ds <= tl)
        begin
            side3_next.kind = KIND_SOUTH;
            side3_next.ay   = ARG_W'(x2_reg);
            side3_next.ax   = ARG_W'(w2_reg);
        end
        else
        begin
            side3_next.kind = KIND_REGULAR;
            side3_next.ay   = hy_reg;
            side3_next.ax   = hx_reg;
        end
    end

    always_comb
    begin
        sq        = (2 * ROOT_W)'(mag3_reg) * (2 * ROOT_W)'(mag3_reg);
        rad4_next = RAD_ONE - sq[RAD_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            xx_reg    <= PROD_W'(qx) * PROD_W'(qx);
            yy_reg    <= PROD_W'(qy) * PROD_W'(qy);
            zz_reg    <= PROD_W'(qz) * PROD_W'(qz);
            ww_reg    <= PROD_W'(qw) * PROD_W'(qw);
            xy_reg    <= PROD_W'(qx) * PROD_W'(qy);
            zw_reg    <= PROD_W'(qz) * PROD_W'(qw);
            yz_reg    <= PROD_W'(qy) * PROD_W'(qz);
            xw_reg    <= PROD_W'(qx) * PROD_W'(qw);
            yw_reg    <= PROD_W'(qy) * PROD_W'(qw);
            xz_reg    <= PROD_W'(qx) * PROD_W'(qz);
            x1_reg    <= qx;
            w1_reg    <= qw;
            test_reg  <= test_next;
            hy_reg    <= hy_next;
            hx_reg    <= hx_next;
            by_reg    <= by_next;
            bx_reg    <= bx_next;
            x2_reg    <= x1_reg;
            w2_reg    <= w1_reg;
            side3_reg <= side3_next;
            mag3_reg  <= mag3_next;
            side4_reg <= side3_reg;
            rad4_reg  <= rad4_next;
        end
    end

    assign out_valid = vld_reg[3];
    assign out_rad   = rad4_reg;
    assign out_side  = side4_reg;

endmodule

>>> rtl/core/q2e_isqrt.sv
module q2e_isqrt (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic [q2e_pkg::RAD_W-1:0]  in_rad,
    input  q2e_pkg::side_t             in_side,
    output logic                       out_valid,
    output logic [q2e_pkg::ROOT_W-1:0] out_root,
    output q2e_pkg::side_t             out_side
);
    import q2e_pkg::*;

    logic [SQRT_STEPS-1:0] vld_reg;
    logic [RAD_W-1:0]      v_reg    [SQRT_STEPS];
    logic [SQRT_W-1:0]     r_reg    [SQRT_STEPS];
    side_t                 side_reg [SQRT_STEPS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[SQRT_STEPS-2:0], in_valid};
        end
    end

    // one result bit per stage, from the top pair of radicand bits down
    for (genvar s = 0; s < SQRT_STEPS; s++)
    begin : g_step
        localparam logic [SQRT_W-1:0] BIT = SQRT_W'(1) << (2 * (SQRT_STEPS - 1 - s));
        logic [RAD_W-1:0]  v_in, v_next;
        logic [SQRT_W-1:0] r_in, r_next, trial;
        side_t             side_in;

        if (s == 0)
        begin : g_first
            assign v_in    = in_rad;
            assign r_in    = '0;
            assign side_in = in_side;
        end
        else
        begin : g_rest
            assign v_in    = v_reg[s-1];
            assign r_in    = r_reg[s-1];
            assign side_in = side_reg[s-1];
        end

        always_comb
        begin
            trial = r_in + BIT;
            if ({1'b0, v_in} >= trial)
            begin
                v_next = v_in - trial[RAD_W-1:0];
                r_next = (r_in >> 1) + BIT;
            end
            else
            begin
                v_next = v_in;
                r_next = r_in >> 1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                v_reg[s]    <= v_next;
                r_reg[s]    <= r_next;
                side_reg[s] <= side_in;
            end
        end
    end

    assign out_valid = vld_reg[SQRT_STEPS-1];
    assign out_root  = r_reg[SQRT_STEPS-1][ROOT_W-1:0];
    assign out_side  = side_reg[SQRT_STEPS-1];

endmodule

>>> rtl/core/q2e_atan2.sv
module q2e_atan2 (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic signed [q2e_pkg::ARG_W-1:0]  y,
    input  logic signed [q2e_pkg::ARG_W-1:0]  x,
    output logic                              out_valid,
    output logic signed [q2e_pkg::Z_W-1:0]    angle
);
    import q2e_pkg::*;

    typedef struct packed {
        logic sx;
        logic sy;
        logic zero;
        logic yz;
        logic xz;
    } quad_t;

    function automatic logic [5:0] msb_pos(input logic [ARG_W-1:0] v);
        logic [5:0] p;
        p = '0;
        for (int i = 0; i < ARG_W; i++)
            if (v[i])
                p = 6'(i);
        return p;
    endfunction

    logic [ATAN_LAT-1:0] vld_reg;

    logic [ARG_W-1:0] ax1_reg, ay1_reg, ax2_reg, ay2_reg;
    logic [5:0]       pos2_reg;
    quad_t            q1_reg, q2_reg, q1_next;

    logic signed [ARG_W-1:0] cx_reg [CORDIC_STEPS + 1];
    logic signed [ARG_W-1:0] cy_reg [CORDIC_STEPS + 1];
    logic signed [Z_W-1:0]   z_reg  [CORDIC_STEPS + 1];
    quad_t                   q_reg  [CORDIC_STEPS + 1];

    logic signed [Z_W-1:0] angle_reg, angle_next;
    logic [ARG_W-1:0]      m2, nx, ny;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[ATAN_LAT-2:0], in_valid};
        end
    end

    always_comb
    begin
        q1_next.sx   = x < 0;
        q1_next.sy   = y < 0;
        q1_next.zero = (x == 0) && (y == 0);
        q1_next.yz   = y == 0;
        q1_next.xz   = x == 0;
    end

    // bring the larger magnitude into [2^29, 2^30); right shifts truncate
    always_comb
    begin
        m2 = (ax1_reg > ay1_reg) ? ax1_reg : ay1_reg;
        if (pos2_reg >= 6'd29)
        begin
            nx = ax2_reg >> (pos2_reg - 6'd29);
            ny = ay2_reg >> (pos2_reg - 6'd29);
        end
        else
        begin
            nx = ax2_reg << (6'd29 - pos2_reg);
            ny = ay2_reg << (6'd29 - pos2_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ax1_reg   <= (x < 0) ? ARG_W'(-x) : ARG_W'(x);
            ay1_reg   <= (y < 0) ? ARG_W'(-y) : ARG_W'(y);
            q1_reg    <= q1_next;
            ax2_reg   <= ax1_reg;
            ay2_reg   <= ay1_reg;
            pos2_reg  <= msb_pos(m2);
            q2_reg    <= q1_reg;
            cx_reg[0] <= $signed(nx);
            cy_reg[0] <= $signed(ny);
            z_reg[0]  <= '0;
            q_reg[0]  <= q2_reg;
            angle_reg <= angle_next;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_rot
        logic signed [ARG_W-1:0] cx_next, cy_next;
        logic signed [Z_W-1:0]   z_next;

        always_comb
        begin
            if (cy_reg[i] > 0)
            begin
                cx_next = cx_reg[i] + (cy_reg[i] >>> i);
                cy_next = cy_reg[i] - (cx_reg[i] >>> i);
                z_next  = z_reg[i] + cordic_angle(i);
            end
            else
            begin
                cx_next = cx_reg[i] - (cy_reg[i] >>> i);
                cy_next = cy_reg[i] + (cx_reg[i] >>> i);
                z_next  = z_reg[i] - cordic_angle(i);
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                cx_reg[i+1] <= cx_next;
                cy_reg[i+1] <= cy_next;
                z_reg[i+1]  <= z_next;
                q_reg[i+1]  <= q_reg[i];
            end
        end
    end

    always_comb
    begin
        quad_t q;
        logic signed [Z_W-1:0] zc;
        q = q_reg[CORDIC_STEPS];
        zc = z_reg[CORDIC_STEPS];
        if (zc < 0)
            zc = '0;
        if (zc > TURN_QUARTER)
            zc = TURN_QUARTER;
        if (q.yz)
            zc = '0;
        else if (q.xz)
            zc = TURN_QUARTER;
        if (q.sx)
            zc = TURN_HALF - zc;
        if (q.sy)
            zc = -zc;
        angle_next = q.zero ? '0 : zc;
    end

    assign out_valid = vld_reg[ATAN_LAT-1];
    assign angle     = angle_reg;

endmodule

>>> rtl/core/quaternion_to_euler.sv
// Quaternion to Euler angles, one quaternion per cycle while the output is not stalled.
// s_axis: s_tdata carries qx, qy, qz, qw (signed Q1.15, qx lowest).
// m_axis: m_tdata carries heading, attitude, bank (16-bit binary angles,
// 32768 = pi, heading lowest); m_tuser carries the pole kind
// (0 regular, 1 north pole, 2 south pole).
// cfg: one write channel for the pole tolerance (units 2^-30), always ready.
// An accepted word passes 4 front-end stages (products, sums, pole test,
// radicand), 31 stages of the bit-pair square root, 36 stages of the
// arctangent units (normalise, 32 CORDIC rotations, quadrant) and the
// output register on its way to m_tvalid.
// Throughput is one word per cycle; every stage is a register with its own
// valid bit, and the three arctangent units run side by side.
// Reset empties the pipeline and loads a tolerance of 1074.
// When m_tready is low with a word held on the output, the whole pipeline
// freezes and s_tready drops; nothing is lost or repeated.
module quaternion_to_euler (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // qx, qy, qz, qw
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // heading, attitude, bank
    output logic [1:0]  m_tuser,   // pole_kind
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [15:0] cfg_data
);
    import q2e_pkg::*;

    function automatic logic signed [Z_W+1:0] to_angle(input logic signed [Z_W+1:0] v);
        return (v + (Z_W + 2)'(32768)) >>> 16;
    endfunction

    logic              en;
    logic [TOL_W-1:0]  tol_reg;

    logic              f_valid;
    logic [RAD_W-1:0]  f_rad;
    side_t             f_side;

    logic              r_valid;
    logic [ROOT_W-1:0] r_root;
    side_t             r_side;

    logic                  a_valid, b_valid, c_valid;
    logic signed [Z_W-1:0] za, zb, zc;

    pole_kind_t kind_reg [ATAN_LAT];

    logic                      m_valid_reg;
    logic [3*ANGLE_W-1:0]      m_data_reg, m_data_next;
    pole_kind_t                m_kind_reg;

    assign en        = !m_valid_reg || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tol_reg <= TOL_RESET;
        end
        else if (cfg_valid)
        begin
            tol_reg <= cfg_data;
        end
    end

    q2e_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_tvalid),
        .qx        (s_tdata[15:0]),
        .qy        (s_tdata[31:16]),
        .qz        (s_tdata[47:32]),
        .qw        (s_tdata[63:48]),
        .tol       (tol_reg),
        .out_valid (f_valid),
        .out_rad   (f_rad),
        .out_side  (f_side)
    );

    q2e_isqrt u_isqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_valid),
        .in_rad    (f_rad),
        .in_side   (f_side),
        .out_valid (r_valid),
        .out_root  (r_root),
        .out_side  (r_side)
    );

    q2e_atan2 u_atan_head (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (r_valid),
        .y         (r_side.ay),
        .x         (r_side.ax),
        .out_valid (a_valid),
        .angle     (za)
    );

    q2e_atan2 u_atan_bank (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (r_valid),
        .y         (r_side.by),
        .x         (r_side.bx),
        .out_valid (b_valid),
        .angle     (zb)
    );

    q2e_atan2 u_atan_att (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (r_valid),
        .y         (ARG_W'(r_side.t30)),
        .x         ($signed(ARG_W'(r_root))),
        .out_valid (c_valid),
        .angle     (zc)
    );

    // pole kind follows the arctangent latency
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            kind_reg[0] <= r_side.kind;
            for (int i = 1; i < ATAN_LAT; i++)
                kind_reg[i] <= kind_reg[i-1];
        end
    end

    always_comb
    begin
        logic signed [Z_W+1:0] hv, hr, br, ar;
        logic signed [ANGLE_W-1:0] att;
        hv = (Z_W + 2)'(za);
        br = to_angle((Z_W + 2)'(zb));
        ar = to_angle((Z_W + 2)'(zc));
        if (ar > (Z_W + 2)'(16384))
            att = 16'sd16384;
        else if (ar < -(Z_W + 2)'(16384))
            att = -16'sd16384;
        else
            att = ANGLE_W'(ar);
        unique case (kind_reg[ATAN_LAT-1])
            KIND_NORTH:
            begin
                hr          = to_angle(-(hv <<< 1));
                m_data_next = {16'sd0, 16'sd16384, hr[ANGLE_W-1:0]};
            end
            KIND_SOUTH:
            begin
                hr          = to_angle(hv <<< 1);
                m_data_next = {16'sd0, -16'sd16384, hr[ANGLE_W-1:0]};
            end
            default:
            begin
                hr          = to_angle(hv);
                m_data_next = {br[ANGLE_W-1:0], att, hr[ANGLE_W-1:0]};
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            m_valid_reg <= a_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            m_data_reg <= m_data_next;
            m_kind_reg <= kind_reg[ATAN_LAT-1];
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_kind_reg;

    a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        a_valid == b_valid && a_valid == c_valid)
        else $error("arctangent lanes out of step");

    a_stall_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> !$past(s_tready) && $stable(m_tdata) && $stable(m_tuser))
        else $error("pipeline moved while output stalled");

    a_pole_angles: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != KIND_REGULAR |->
        m_tdata[47:32] == 16'd0 &&
        (m_tdata[31:16] == 16'h4000 || m_tdata[31:16] == 16'hc000))
        else $error("pole word with bank or attitude off");

    a_att_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> $signed(m_tdata[31:16]) >= -16'sd16384 &&
        $signed(m_tdata[31:16]) <= 16'sd16384 && m_tuser != 2'd3)
        else $error("attitude out of range or bad pole kind");

endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import q2e_pkg::*;

    typedef struct packed {
        logic [15:0] heading;
        logic [15:0] attitude;
        logic [15:0] bank;
        pole_kind_t  kind;
    } euler_t;

    // arctan(2^-i), 2^-32 turn
    localparam longint ATAN_STEP [32] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21353441,
        10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
        41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20, 10,
        5, 3, 1, 1, 0};

    class euler_scoreboard;
        euler_t       pending[$];
        longint       tolerance;
        int           errors;

        function new();
            tolerance = 1074;
            errors    = 0;
        endfunction

        static function longint cordic_atan2(longint y, longint x);
            longint ax, ay, mx, cx, cy, dx, dy, z;
            z = 0;
            if (x == 0 && y == 0)
                return 0;
            ax = x < 0 ? -x : x;
            ay = y < 0 ? -y : y;
            if (ay == 0)
                z = 0;
            else if (ax == 0)
                z = 64'sd1 << 30;
            else
            begin
                mx = ax > ay ? ax : ay;
                while (mx >= (64'sd1 << 30))
                begin
                    ax = ax >>> 1; ay = ay >>> 1; mx = mx >>> 1;
                end
                while (mx < (64'sd1 << 29))
                begin
                    ax = ax <<< 1; ay = ay <<< 1; mx = mx <<< 1;
                end
                cx = ax;
                cy = ay;
                for (int i = 0; i < 32; i++)
                begin
                    dx = cy >>> i;
                    dy = cx >>> i;
                    if (cy > 0)
                    begin
                        cx += dx; cy -= dy; z += ATAN_STEP[i];
                    end
                    else
                    begin
                        cx -= dx; cy += dy; z -= ATAN_STEP[i];
                    end
                end
                if (z < 0) z = 0;
                if (z > (64'sd1 << 30)) z = 64'sd1 << 30;
            end
            if (x < 0) z = (64'sd1 << 31) - z;
            if (y < 0) z = -z;
            return z;
        endfunction

        static function longint to_bam(longint z);
            return (z + (64'sd1 << 15)) >>> 16;
        endfunction

        static function longint floor_sqrt(longint v);
            longint r, b;
            r = 0;
            b = 64'sd1 << 62;
            while (b > v) b = b >> 2;
            while (b != 0)
            begin
                if (v >= r + b)
                begin
                    v -= r + b;
                    r = (r >> 1) + b;
                end
                else
                    r = r >> 1;
                b = b >> 2;
            end
            return r;
        endfunction

        function void note_quaternion(logic [63:0] word);
            longint x, y, z, w, test, one, dn, ds, xx, yy, zz, ww, t, mag, c, att;
            euler_t e;
            x = longint'($signed(word[15:0]));
            y = longint'($signed(word[31:16]));
            z = longint'($signed(word[47:32]));
            w = longint'($signed(word[63:48]));
            one = 64'sd1 << 30;
            test = 2 * (y * w - x * z);
            dn = test - one;
            ds = test + one;
            if (dn >= -tolerance && dn <= tolerance)
            begin
                e.heading  = 16'(to_bam(-2 * cordic_atan2(x, w)));
                e.attitude = 16'sd16384;
                e.bank     = '0;
                e.kind     = KIND_NORTH;
            end
            else if (ds >= -tolerance && ds <= tolerance)
            begin
                e.heading  = 16'(to_bam(2 * cordic_atan2(x, w)));
                e.attitude = -16'sd16384;
                e.bank     = '0;
                e.kind     = KIND_SOUTH;
            end
            else
            begin
                xx = x * x; yy = y * y; zz = z * z; ww = w * w;
                e.heading = 16'(to_bam(cordic_atan2(2 * (x * y + z * w), xx - yy - zz + ww)));
                e.bank    = 16'(to_bam(cordic_atan2(2 * (y * z + x * w), -xx - yy + zz + ww)));
                t = test;
                if (t > one) t = one;
                if (t < -one) t = -one;
                mag = t < 0 ? -t : t;
                c = floor_sqrt((64'sd1 << 60) - mag * mag);
                att = to_bam(cordic_atan2(t < 0 ? -mag : mag, c));
                if (att > 16384) att = 16384;
                if (att < -16384) att = -16384;
                e.attitude = 16'(att);
                e.kind     = KIND_REGULAR;
            end
            pending.push_back(e);
        endfunction

        function void check_angles(logic [47:0] data, logic [1:0] user);
            euler_t e;
            if (pending.size() == 0)
            begin
                $error("unexpected word %h/%0d", data, user);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (data[15:0] !== e.heading)
            begin
                $error("heading: expected %h, got %h", e.heading, data[15:0]);
                errors++;
            end
            if (data[31:16] !== e.attitude)
            begin
                $error("attitude: expected %h, got %h", e.attitude, data[31:16]);
                errors++;
            end
            if (data[47:32] !== e.bank)
            begin
                $error("bank: expected %h, got %h", e.bank, data[47:32]);
                errors++;
            end
            if (user !== e.kind)
            begin
                $error("pole_kind: expected %0d, got %0d", e.kind, user);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [15:0] cfg_data = '0;

    euler_scoreboard angles = new();
    longint cycles = 0;
    bit     hold_off = 1'b0;

    quaternion_to_euler i_dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    function automatic int gap_len();
        if ($urandom_range(0, 19) == 0)
            return $urandom_range(10, 60);
        if ($urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(1, 3);
    endfunction

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 400000)
        begin
            $display("tb_top: errors");
            $finish;
        end
        if (m_tvalid && m_tready)
            angles.check_angles(m_tdata, m_tuser);
    end

    // receiver: random stalls, or a long hold-off on request
    initial
    begin
        int g;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off)
                m_tready <= 1'b0;
            else
            begin
                g = gap_len();
                if (g == 0 || $urandom_range(0, 3) == 0)
                    m_tready <= 1'b1;
                else
                begin
                    m_tready <= 1'b0;
                    repeat (g - 1) @(negedge clk);
                end
            end
        end
    end

    task automatic send_word(logic [63:0] word, bit no_gap);
        int g;
        g = no_gap ? 0 : gap_len();
        if (g > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (g) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        angles.note_quaternion(word);
        @(negedge clk);
    endtask

    // the sender is already idle when this is called
    task automatic write_tolerance(logic [15:0] v);
        while (angles.pending.size() != 0) @(negedge clk);
        repeat (100) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        angles.tolerance = longint'(v);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [63:0] pack_q(int x, int y, int z, int w);
        return {w[15:0], z[15:0], y[15:0], x[15:0]};
    endfunction

    // near-pole quaternion: y*w - x*z close to +/-1/2
    function automatic logic [63:0] near_pole(bit south);
        int a, b, x, y, z, w;
        a = $urandom_range(0, 23170);
        b = 23170 + $urandom_range(0, 2) - 1;
        x = $signed(16'($urandom())) / 4;
        w = a;
        y = south ? -b : b;
        z = south ? -(x * w / 23170) : (x * w / 23170);
        x = $urandom_range(0, 1) ? x : -x;
        w = 23170 - $urandom_range(0, 3);
        y = south ? -23170 + $urandom_range(0, 3) : 23170 - $urandom_range(0, 3);
        if ($urandom_range(0, 1))
        begin
            x = 0; z = 0;
        end
        else
        begin
            x = $urandom_range(0, 40) - 20; z = $urandom_range(0, 40) - 20;
        end
        return pack_q(x, y, z, w);
    endfunction

    task automatic random_phase(int n);
        logic [63:0] word;
        int k;
        for (int i = 0; i < n; i++)
        begin
            k = $urandom_range(0, 9);
            if (k < 2)
                word = near_pole(k[0]);
            else if (k < 4)
                word = {$urandom(), $urandom()};
            else
                word = pack_q($signed(16'($urandom())) / 2, $signed(16'($urandom())) / 2,
                              $signed(16'($urandom())) / 2, $signed(16'($urandom())) / 2);
            send_word(word, $urandom_range(0, 4) == 0);
        end
        s_tvalid <= 1'b0;
    endtask

    initial
    begin
        repeat (12) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        // identity, extremes, both poles, zero, all-min, all-max
        send_word(pack_q(0, 0, 0, 32767), 1);
        send_word(pack_q(0, 0, 0, 0), 1);
        send_word(pack_q(-32768, -32768, -32768, -32768), 1);
        send_word(pack_q(32767, 32767, 32767, 32767), 1);
        send_word(pack_q(-32768, 0, 0, 0), 1);
        send_word(pack_q(0, -32768, 0, 0), 1);
        send_word(pack_q(0, 0, -32768, 0), 1);
        send_word(pack_q(0, 0, 0, -32768), 1);
        send_word(pack_q(0, 23170, 0, 23170), 0);
        send_word(pack_q(0, -23170, 0, 23170), 0);
        send_word(pack_q(5000, 23170, 5000, 23170), 0);
        send_word(pack_q(-5000, -23170, 5000, 23170), 0);
        send_word(pack_q(32767, -32768, 32767, -32768), 0);
        send_word(pack_q(-32768, 0, 32767, 0), 0);
        send_word(pack_q(16384, 16384, 16384, 16384), 0);
        send_word(pack_q(0, 32767, 0, 32767), 0);
        random_phase(200);
        // long receiver hold-off while the sender keeps offering
        fork
            begin
                hold_off = 1'b1;
                repeat (300) @(negedge clk);
                hold_off = 1'b0;
            end
            random_phase(150);
        join
        write_tolerance(16'd0);
        send_word(pack_q(0, 23170, 0, 23170), 0);
        random_phase(150);
        write_tolerance(16'hFFFF);
        send_word(pack_q(0, 23170, 0, 23170), 0);
        random_phase(150);
        write_tolerance(16'($urandom()));
        random_phase(200);
        write_tolerance(16'd1074);
        s_tvalid <= 1'b0;
        while (angles.pending.size() != 0) @(negedge clk);
        repeat (100) @(negedge clk);
        if (angles.errors == 0)
            $display("tb_top: clean");
        else
            $display("tb_top: errors");
        $finish;
    end
endmodule
